FILE: rtl/core/lfma_pkg.sv
// ----------------------------------------------------------------------------
// lfma_pkg
// Types and constants shared by the lowest-free allocator modules.
// ----------------------------------------------------------------------------
package lfma_pkg;

  localparam int TYPE_W     = 2;
  localparam int REQ_W      = 8;
  localparam int ID_W       = 6;
  localparam int CNT_W      = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_ALLOC,
    ST_COUNT
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_alloc;
    logic load_single;
    logic count_step;
  } cmd_t;

  typedef struct packed {
    logic in_is_alloc;
    logic slot_free;
    logic alloc_last;
    logic sweep_done;
  } status_t;

endpackage

FILE: rtl/core/lfma_ctrl.sv
// ----------------------------------------------------------------------------
// lfma_ctrl
// Sequencer: takes one request, steps the datapath through its results.
// ----------------------------------------------------------------------------
module lfma_ctrl
  import lfma_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    in_tvalid_i,
  output logic    in_tready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_tready_o = !cfg_we_i;
        if (cfg_we_i) begin
          state_d = ST_COUNT;
        end else if (in_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = st_i.in_is_alloc ? ST_ALLOC : ST_SINGLE;
        end
      end
      ST_SINGLE: begin
        if (st_i.slot_free) begin
          cmd_o.load_single = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        if (st_i.slot_free) begin
          cmd_o.load_alloc = 1'b1;
          if (st_i.alloc_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_COUNT: begin
        if (cfg_we_i) begin
          state_d = ST_COUNT;
        end else if (st_i.sweep_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.count_step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/lfma_datapath.sv
// ----------------------------------------------------------------------------
// lfma_datapath
// Busy bitmap, lowest-free search, counters and the result register.
// ----------------------------------------------------------------------------
module lfma_datapath
  import lfma_pkg::*;
#(
  parameter int MAX_ARRAYS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               st_o,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic [TYPE_W-1:0]     in_tuser_i,
  input  logic [IN_DATA_W-1:0]  in_tdata_i,
  input  logic                  out_tready_i,
  output logic                  out_tvalid_o,
  output logic [OUT_DATA_W-1:0] out_tdata_o,
  output logic                  out_tuser_o,
  output logic                  out_tlast_o
);

  localparam int IDX_W = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ARRAYS);

  logic [MAX_ARRAYS-1:0] busy_q, busy_d;
  logic [CNT_W-1:0]      pool_q, pool_d;
  logic [CNT_W-1:0]      free_q, free_d;
  logic [CNT_W-1:0]      sweep_q, sweep_d;
  logic [CNT_W-1:0]      got_q, got_d;
  logic [CNT_W-1:0]      needed_q, needed_d;
  logic [TYPE_W-1:0]     type_q, type_d;
  logic [ID_W-1:0]       rid_q, rid_d;
  logic                  out_valid_q, out_valid_d;

  logic [ID_W-1:0]  o_id_q, o_id_d;
  logic             o_vld_q, o_vld_d;
  logic [CNT_W-1:0] o_got_q, o_got_d;
  logic [CNT_W-1:0] o_need_q, o_need_d;
  logic [CNT_W-1:0] o_free_q, o_free_d;
  logic             o_last_q, o_last_d;

  logic [MAX_ARRAYS-1:0] pool_mask, free_vec, low_oh;
  logic [IDX_W-1:0]      low_idx;
  logic                  found, has_more, grant_ok, grant_last;
  logic                  rid_in_pool, rid_busy, free_bit;
  logic [REQ_W-1:0]      req_in;
  logic [CNT_W-1:0]      got_inc;

  assign req_in = in_tdata_i[REQ_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_ARRAYS; i++) begin
      pool_mask[i] = CNT_W'(i) < pool_q;
    end
  end

  assign free_vec = ~busy_q & pool_mask;
  assign low_oh   = free_vec & (~free_vec + MAX_ARRAYS'(1));
  assign found    = |free_vec;
  assign has_more = |(free_vec & (free_vec - MAX_ARRAYS'(1)));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MAX_ARRAYS; i++) begin
      if (low_oh[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  assign got_inc     = got_q + CNT_W'(1);
  assign grant_ok    = found && (got_q < needed_q);
  assign grant_last  = !grant_ok || (got_inc == needed_q) || !has_more;
  assign rid_in_pool = CNT_W'(rid_q) < pool_q;
  assign rid_busy    = busy_q[rid_q[IDX_W-1:0]];
  assign free_bit    = !busy_q[sweep_q[IDX_W-1:0]];

  assign st_o.in_is_alloc = in_tuser_i == REQ_ALLOC;
  assign st_o.slot_free   = !out_valid_q || out_tready_i;
  assign st_o.alloc_last  = grant_last;
  assign st_o.sweep_done  = sweep_q == pool_q;

  always_comb begin
    busy_d      = busy_q;
    pool_d      = pool_q;
    free_d      = free_q;
    sweep_d     = sweep_q;
    got_d       = got_q;
    needed_d    = needed_q;
    type_d      = type_q;
    rid_d       = rid_q;
    out_valid_d = out_valid_q && !out_tready_i;
    o_id_d      = o_id_q;
    o_vld_d     = o_vld_q;
    o_got_d     = o_got_q;
    o_need_d    = o_need_q;
    o_free_d    = o_free_q;
    o_last_d    = o_last_q;

    if (cmd_i.accept) begin
      type_d = in_tuser_i;
      rid_d  = in_tdata_i[REQ_W +: ID_W];
      got_d  = '0;
      if (REQ_W'(pool_q) < req_in) begin
        needed_d = pool_q;
      end else begin
        needed_d = req_in[CNT_W-1:0];
      end
    end

    if (cmd_i.load_alloc) begin
      out_valid_d = 1'b1;
      o_need_d    = needed_q;
      o_last_d    = grant_last;
      if (grant_ok) begin
        busy_d   = busy_q | low_oh;
        got_d    = got_inc;
        free_d   = free_q - CNT_W'(1);
        o_id_d   = ID_W'(low_idx);
        o_vld_d  = 1'b1;
        o_got_d  = got_inc;
        o_free_d = free_q - CNT_W'(1);
      end else begin
        o_id_d   = '0;
        o_vld_d  = 1'b0;
        o_got_d  = '0;
        o_free_d = free_q;
      end
    end

    if (cmd_i.load_single) begin
      out_valid_d = 1'b1;
      o_id_d      = '0;
      o_vld_d     = 1'b0;
      o_got_d     = '0;
      o_need_d    = '0;
      o_last_d    = 1'b1;
      o_free_d    = free_q;
      if (type_q == REQ_RELEASE) begin
        if (rid_in_pool && rid_busy) begin
          busy_d[rid_q[IDX_W-1:0]] = 1'b0;
          free_d   = free_q + CNT_W'(1);
          o_free_d = free_q + CNT_W'(1);
        end
      end else if (type_q == REQ_CLEAR) begin
        busy_d   = '0;
        free_d   = pool_q;
        o_free_d = pool_q;
      end
    end

    if (cmd_i.count_step) begin
      free_d  = free_q + CNT_W'(free_bit);
      sweep_d = sweep_q + CNT_W'(1);
    end

    if (cfg_we_i) begin
      pool_d  = (cfg_wdata_i > MAX_CNT) ? MAX_CNT : cfg_wdata_i;
      free_d  = '0;
      sweep_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      pool_q      <= MAX_CNT;
      free_q      <= MAX_CNT;
      sweep_q     <= MAX_CNT;
      got_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pool_q      <= pool_d;
      free_q      <= free_d;
      sweep_q     <= sweep_d;
      got_q       <= got_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    needed_q <= needed_d;
    type_q   <= type_d;
    rid_q    <= rid_d;
    o_id_q   <= o_id_d;
    o_vld_q  <= o_vld_d;
    o_got_q  <= o_got_d;
    o_need_q <= o_need_d;
    o_free_q <= o_free_d;
    o_last_q <= o_last_d;
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = OUT_DATA_W'({o_free_q, o_need_q, o_got_q, o_id_q});
  assign out_tuser_o  = o_vld_q;
  assign out_tlast_o  = o_last_q;

endmodule

FILE: rtl/core/lowest_free_multi_allocator_top.sv
// ----------------------------------------------------------------------------
// lowest_free_multi_allocator_top
// Lowest-free allocator over a pool of compute arrays, one id per result.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis group: tuser holds the request kind
// (allocate, release one id, clear all), tdata the count and release id.
// Results leave on the m_axis group, one per granted id in ascending order,
// tlast on the final result of a request; tuser is the id-valid flag.
// A request that grants nothing, a release and a clear give one result.
// Timing: the first result is registered from the ALLOC or SINGLE state that
// follows acceptance; an allocate then yields one id per cycle while the
// receiver takes each result, set by the single lowest-free search unit.
// The next request is taken in the cycle after the last result is loaded,
// even while that result still waits in the output register.
// A stalled receiver holds the result register and the sequencer waits.
// cfg_we_i writes the pool size; a count sweep over the pool follows to
// rebuild the free count, with s_axis_tready_o low until the sweep is done.
// Reset frees every array and sets the pool to MAX_ARRAYS, with no sweep.
// ----------------------------------------------------------------------------
module lowest_free_multi_allocator_top
  import lfma_pkg::*;
#(
  parameter int MAX_ARRAYS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // request_count [7:0], release_id [13:8], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type [1:0]
  input  logic [TYPE_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // granted_id [5:0], granted_count [12:6], needed_count [19:13],
  // free_count [26:20], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // id_valid [0]
  output logic                  m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  cmd_t    cmd;
  status_t st;

  lfma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_tvalid_i (s_axis_tvalid_i),
    .in_tready_o (s_axis_tready_o),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  lfma_datapath #(
    .MAX_ARRAYS (MAX_ARRAYS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .in_tdata_i   (s_axis_tdata_i),
    .out_tready_i (m_axis_tready_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tdata_o  (m_axis_tdata_o),
    .out_tuser_o  (m_axis_tuser_o),
    .out_tlast_o  (m_axis_tlast_o)
  );

  property p_one_request_at_a_time;
    @(posedge clk_i) disable iff (!rst_ni)
      (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o;
  endproperty
  assert property (p_one_request_at_a_time)
    else $error("request taken while another is in progress");

  property p_grant_within_need;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && m_axis_tuser_o) |->
        (m_axis_tdata_o[12:6] != 7'd0) && (m_axis_tdata_o[12:6] <= m_axis_tdata_o[19:13]);
  endproperty
  assert property (p_grant_within_need)
    else $error("granted count outside one to needed count");

  property p_empty_result_is_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o;
  endproperty
  assert property (p_empty_result_is_last)
    else $error("result without a granted id is not last");

endmodule

FILE: tb/lowest_free_multi_allocator_checker.sv
// ----------------------------------------------------------------------------
// lowest_free_multi_allocator_checker
// Watches the request, result and pool-size ports of the allocator, keeps its
// own busy map and pool size, works out the results each request should give
// and compares every delivered result field by field, oldest first.
// ----------------------------------------------------------------------------
module lowest_free_multi_allocator_checker
  import lfma_pkg::*;
#(
  parameter int MAX_ARRAYS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // request_count [7:0], release_id [13:8], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type [1:0]
  input  logic [TYPE_W-1:0]     s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // granted_id [5:0], granted_count [12:6], needed_count [19:13],
  // free_count [26:20], zero fill
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  // id_valid [0]
  input  logic                  m_axis_tuser_i,
  input  logic                  m_axis_tlast_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             id_valid;
    logic [CNT_W-1:0] granted;
    logic [CNT_W-1:0] needed;
    logic [CNT_W-1:0] free;
    logic             last;
  } grant_result_t;

  logic [MAX_ARRAYS-1:0] busy_arrays  = '0;
  logic [CNT_W-1:0]      pool_setting = CNT_W'(MAX_ARRAYS);
  grant_result_t         grant_result_q[$];

  function automatic int unsigned pool_limit();
    return (pool_setting > MAX_ARRAYS) ? MAX_ARRAYS : pool_setting;
  endfunction

  function automatic int unsigned free_in_pool();
    int unsigned cnt;
    cnt = 0;
    for (int i = 0; i < pool_limit(); i++) begin
      if (!busy_arrays[i]) cnt++;
    end
    return cnt;
  endfunction

  task automatic queue_result(input grant_result_t res);
    grant_result_q.insert(grant_result_q.size(), res);
  endtask

  task automatic predict_grants(input logic [TYPE_W-1:0] kind,
                                input logic [REQ_W-1:0]  want,
                                input logic [ID_W-1:0]   rid);
    int unsigned   pool;
    int unsigned   needed;
    int unsigned   got;
    int unsigned   freec;
    grant_result_t res;
    pool = pool_limit();
    res  = '0;
    if (kind == REQ_ALLOC) begin
      needed = (want < pool) ? want : pool;
      got    = 0;
      freec  = free_in_pool();
      for (int i = 0; i < pool && got < needed; i++) begin
        if (!busy_arrays[i]) begin
          if (got != 0) queue_result(res);
          busy_arrays[i] = 1'b1;
          got++;
          freec--;
          res = '{id: ID_W'(i), id_valid: 1'b1, granted: CNT_W'(got),
                  needed: CNT_W'(needed), free: CNT_W'(freec), last: 1'b0};
        end
      end
      if (got == 0) begin
        res = '{id: '0, id_valid: 1'b0, granted: '0, needed: CNT_W'(needed),
                free: CNT_W'(freec), last: 1'b0};
      end
    end else begin
      if (kind == REQ_RELEASE && rid < pool) busy_arrays[rid] = 1'b0;
      if (kind == REQ_CLEAR) busy_arrays = '0;
      res.free = CNT_W'(free_in_pool());
    end
    res.last = 1'b1;
    queue_result(res);
  endtask

  task automatic compare_field(input string name, input int unsigned expv,
                               input int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    grant_result_t exp_res;
    if (grant_result_q.size() == 0) begin
      $error("result: none expected, got tdata %h", m_axis_tdata_i);
      fail_count_o++;
    end else begin
      exp_res = grant_result_q.pop_front();
      compare_field("granted_id", exp_res.id, m_axis_tdata_i[5:0]);
      compare_field("id_valid", exp_res.id_valid, m_axis_tuser_i);
      compare_field("granted_count", exp_res.granted, m_axis_tdata_i[12:6]);
      compare_field("needed_count", exp_res.needed, m_axis_tdata_i[19:13]);
      compare_field("free_count", exp_res.free, m_axis_tdata_i[26:20]);
      compare_field("last", exp_res.last, m_axis_tlast_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      busy_arrays  = '0;
      pool_setting = CNT_W'(MAX_ARRAYS);
      grant_result_q.delete();
    end else begin
      if (cfg_we_i) pool_setting = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_grants(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[13:8]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
    end
    pending_o = grant_result_q.size();
  end

endmodule

FILE: tb/tb_lowest_free_multi_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_lowest_free_multi_allocator_top
// Drives allocate, release, clear and unused requests plus pool-size writes
// into the allocator, first a directed sequence, then random phases with
// different pool sizes and sender/receiver idling; a checker module predicts
// and compares every result and the verdict comes from its failure count.
// ----------------------------------------------------------------------------
module tb_lowest_free_multi_allocator_top;
  import lfma_pkg::*;

  localparam int                MAX_ARRAYS     = 64;
  localparam logic [TYPE_W-1:0] REQ_UNUSED     = 2'd3;
  localparam int                PHASES         = 7;
  localparam int                PHASE_ITEMS    = 34;
  localparam int                DRAIN_CYCLES   = 20;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [TYPE_W-1:0]     s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  int                    fail_count;
  int                    pending;
  int                    gap_pct   = 0;
  int                    stall_pct = 0;
  int unsigned           cur_pool  = MAX_ARRAYS;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lowest_free_multi_allocator_top #(
    .MAX_ARRAYS(MAX_ARRAYS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  lowest_free_multi_allocator_checker #(
    .MAX_ARRAYS(MAX_ARRAYS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_request(input logic [TYPE_W-1:0] kind,
                              input logic [REQ_W-1:0]  want,
                              input logic [ID_W-1:0]   rid);
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = {2'b00, rid, want};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_pool_size(input logic [CNT_W-1:0] size);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = size;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_pool = (size > MAX_ARRAYS) ? MAX_ARRAYS : size;
  endtask

  task automatic send_random_request();
    int unsigned      pick;
    logic [REQ_W-1:0] want;
    logic [ID_W-1:0]  rid;
    pick = $urandom_range(99);
    want = REQ_W'($urandom_range(255));
    rid  = ID_W'($urandom_range(63));
    if ($urandom_range(99) < 2) wait_drained();
    if (pick < 45) begin
      pick = $urandom_range(99);
      if (pick < 70) want = REQ_W'($urandom_range(6));
      else if (pick < 90) want = REQ_W'($urandom_range(70));
      send_request(REQ_ALLOC, want, rid);
    end else if (pick < 85) begin
      if (cur_pool != 0 && $urandom_range(99) < 80) rid = ID_W'($urandom_range(cur_pool - 1));
      send_request(REQ_RELEASE, want, rid);
    end else if (pick < 95) begin
      send_request(REQ_CLEAR, want, rid);
    end else begin
      send_request(REQ_UNUSED, want, rid);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] phase_pool [PHASES];
    int               phase_gap  [4];
    int               phase_stall[4];
    phase_pool  = '{7'd5, 7'd64, 7'd127, 7'd1, CNT_W'($urandom_range(2, 63)), 7'd0, 7'd64};
    phase_gap   = '{0, 83, 0, 14};
    phase_stall = '{0, 0, 83, 14};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty, partial and oversized allocates, full pool
    send_request(REQ_ALLOC, 8'd0, 6'd0);
    send_request(REQ_ALLOC, 8'd1, 6'd63);
    send_request(REQ_ALLOC, 8'd3, 6'd0);
    send_request(REQ_RELEASE, 8'd0, 6'd2);
    send_request(REQ_RELEASE, 8'd255, 6'd63);
    send_request(REQ_ALLOC, 8'd255, 6'd0);
    send_request(REQ_ALLOC, 8'd1, 6'd0);
    send_request(REQ_RELEASE, 8'd0, 6'd0);
    send_request(REQ_RELEASE, 8'd0, 6'd63);
    send_request(REQ_ALLOC, 8'd2, 6'd0);
    send_request(REQ_UNUSED, 8'd0, 6'd0);
    send_request(REQ_CLEAR, 8'd0, 6'd0);
    send_request(REQ_ALLOC, 8'd64, 6'd0);
    // shrink the pool while every array is busy
    write_pool_size(7'd8);
    send_request(REQ_RELEASE, 8'd0, 6'd10);
    send_request(REQ_RELEASE, 8'd0, 6'd5);
    send_request(REQ_ALLOC, 8'd2, 6'd0);
    write_pool_size(7'd64);
    send_request(REQ_ALLOC, 8'd255, 6'd0);
    send_request(REQ_CLEAR, 8'd0, 6'd0);
    // empty pool, then saturated pool size
    write_pool_size(7'd0);
    send_request(REQ_ALLOC, 8'd5, 6'd0);
    send_request(REQ_RELEASE, 8'd0, 6'd0);
    write_pool_size(7'd127);
    send_request(REQ_ALLOC, 8'd200, 6'd0);
    send_request(REQ_UNUSED, 8'd255, 6'd63);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_pool_size(phase_pool[ph]);
      gap_pct   = phase_gap[ph % 4];
      stall_pct = phase_stall[ph % 4];
      for (int k = 0; k < PHASE_ITEMS; k++) send_random_request();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
